[hdl/s27hne_pkg.sv]
// ---------------------------------------------------------------------------
// s27hne_pkg
// Shared types, constants and the stencil direction table for the
// 27-point halo neighbour enumerator.
// ---------------------------------------------------------------------------
package s27hne_pkg;

    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int SIZE_W      = 9;
    localparam int COORD_W     = 8;
    localparam int NC_W        = COORD_W + 1;
    localparam int EXT_W       = (DIM_W > NC_W) ? DIM_W : NC_W;
    localparam int BYTES_W     = 32;
    localparam int IDX_W       = 24;
    localparam int NUM_DIRS    = 26;
    localparam int DIR_W       = $clog2(NUM_DIRS);
    localparam int NUM_CLS     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIVC_W      = $clog2(BYTES_W);
    localparam int T_W         = DIM_W + NC_W;
    localparam int P_W         = DIM_W + T_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_BYTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_BYTES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BYTES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIT_BYTES   = 3'd6;

    typedef logic [1:0] st_t;
    localparam st_t ST_NBR   = 2'd0;
    localparam st_t ST_LONE  = 2'd1;
    localparam st_t ST_RANGE = 2'd2;

    typedef logic [1:0] cls_t;
    localparam cls_t CLS_FACE   = 2'd0;
    localparam cls_t CLS_EDGE   = 2'd1;
    localparam cls_t CLS_CORNER = 2'd2;

    typedef logic [1:0] ofs_t;
    localparam ofs_t OFS_ZERO = 2'd0;
    localparam ofs_t OFS_NEG  = 2'd1;
    localparam ofs_t OFS_POS  = 2'd2;

    typedef struct packed {
        ofs_t dx;
        ofs_t dy;
        ofs_t dz;
        cls_t cls;
    } dir_t;

    // faces, then edges, then corners
    localparam dir_t DIR_TAB [NUM_DIRS] = '{
        '{OFS_NEG,  OFS_ZERO, OFS_ZERO, CLS_FACE},
        '{OFS_POS,  OFS_ZERO, OFS_ZERO, CLS_FACE},
        '{OFS_ZERO, OFS_NEG,  OFS_ZERO, CLS_FACE},
        '{OFS_ZERO, OFS_POS,  OFS_ZERO, CLS_FACE},
        '{OFS_ZERO, OFS_ZERO, OFS_NEG,  CLS_FACE},
        '{OFS_ZERO, OFS_ZERO, OFS_POS,  CLS_FACE},
        '{OFS_NEG,  OFS_NEG,  OFS_ZERO, CLS_EDGE},
        '{OFS_NEG,  OFS_POS,  OFS_ZERO, CLS_EDGE},
        '{OFS_POS,  OFS_NEG,  OFS_ZERO, CLS_EDGE},
        '{OFS_POS,  OFS_POS,  OFS_ZERO, CLS_EDGE},
        '{OFS_ZERO, OFS_NEG,  OFS_NEG,  CLS_EDGE},
        '{OFS_ZERO, OFS_NEG,  OFS_POS,  CLS_EDGE},
        '{OFS_ZERO, OFS_POS,  OFS_NEG,  CLS_EDGE},
        '{OFS_ZERO, OFS_POS,  OFS_POS,  CLS_EDGE},
        '{OFS_NEG,  OFS_ZERO, OFS_NEG,  CLS_EDGE},
        '{OFS_POS,  OFS_ZERO, OFS_NEG,  CLS_EDGE},
        '{OFS_NEG,  OFS_ZERO, OFS_POS,  CLS_EDGE},
        '{OFS_POS,  OFS_ZERO, OFS_POS,  CLS_EDGE},
        '{OFS_NEG,  OFS_NEG,  OFS_NEG,  CLS_CORNER},
        '{OFS_NEG,  OFS_NEG,  OFS_POS,  CLS_CORNER},
        '{OFS_NEG,  OFS_POS,  OFS_NEG,  CLS_CORNER},
        '{OFS_NEG,  OFS_POS,  OFS_POS,  CLS_CORNER},
        '{OFS_POS,  OFS_NEG,  OFS_NEG,  CLS_CORNER},
        '{OFS_POS,  OFS_NEG,  OFS_POS,  CLS_CORNER},
        '{OFS_POS,  OFS_POS,  OFS_NEG,  CLS_CORNER},
        '{OFS_POS,  OFS_POS,  OFS_POS,  CLS_CORNER}
    };

    typedef struct packed {
        logic [DIM_W-1:0]                xn;
        logic [DIM_W-1:0]                yn;
        logic [DIM_W-1:0]                zn;
        logic [NUM_CLS-1:0][BYTES_W-1:0] flits;
        logic                            busy;
    } cfg_t;

    typedef struct packed {
        st_t                 st;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [NUM_DIRS-1:0] mask;
    } q_entry_t;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [SIZE_W-1:0] v);
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

endpackage

[hdl/s27hne_cfg.sv]
// ---------------------------------------------------------------------------
// s27hne_cfg
// Configuration registers and the shared serial divider that works out the
// flit count of each neighbour class after a byte or flit size write.
// ---------------------------------------------------------------------------
module s27hne_cfg
    import s27hne_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTES_W-1:0]   cfg_data,
    output cfg_t                 cfg_o
);

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_LOAD,
        CS_DIV,
        CS_STORE
    } cstate_t;

    cstate_t                         state_reg;
    logic [SIZE_W-1:0]               x_size_reg;
    logic [SIZE_W-1:0]               y_size_reg;
    logic [SIZE_W-1:0]               z_size_reg;
    logic [BYTES_W-1:0]              face_bytes_reg;
    logic [BYTES_W-1:0]              edge_bytes_reg;
    logic [BYTES_W-1:0]              corner_bytes_reg;
    logic [BYTES_W-1:0]              flit_bytes_reg;
    logic [NUM_CLS-1:0][BYTES_W-1:0] flits_reg;
    cls_t                            cls_cnt_reg;
    logic [DIVC_W-1:0]               div_cnt_reg;
    logic [BYTES_W-1:0]              div_q_reg;
    logic [BYTES_W-1:0]              div_r_reg;

    logic                            wr;
    logic                            restart;
    logic [BYTES_W-1:0]              dividend;
    logic [BYTES_W:0]                rem_sh;
    logic [BYTES_W:0]                rem_sub;
    logic                            q_bit;
    logic [BYTES_W-1:0]              rem_new;
    logic [BYTES_W-1:0]              ceil_q;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign restart   = wr && (cfg_index == REG_FACE_BYTES || cfg_index == REG_EDGE_BYTES ||
                              cfg_index == REG_CORNER_BYTES || cfg_index == REG_FLIT_BYTES);

    always_comb begin
        unique case (cls_cnt_reg)
            CLS_FACE:   dividend = face_bytes_reg;
            CLS_EDGE:   dividend = edge_bytes_reg;
            CLS_CORNER: dividend = corner_bytes_reg;
            default:    dividend = '0;
        endcase
    end

    // one restoring step a cycle
    always_comb begin
        rem_sh  = {div_r_reg, div_q_reg[BYTES_W-1]};
        rem_sub = rem_sh - {1'b0, flit_bytes_reg};
        q_bit   = (rem_sh >= {1'b0, flit_bytes_reg});
        rem_new = q_bit ? rem_sub[BYTES_W-1:0] : rem_sh[BYTES_W-1:0];
        ceil_q  = div_q_reg + BYTES_W'(div_r_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= CS_IDLE;
            x_size_reg       <= SIZE_W'(1);
            y_size_reg       <= SIZE_W'(1);
            z_size_reg       <= SIZE_W'(1);
            face_bytes_reg   <= BYTES_W'(1);
            edge_bytes_reg   <= BYTES_W'(1);
            corner_bytes_reg <= BYTES_W'(1);
            flit_bytes_reg   <= BYTES_W'(1);
            flits_reg        <= {NUM_CLS{BYTES_W'(1)}};
            cls_cnt_reg      <= CLS_FACE;
            div_cnt_reg      <= '0;
        end else begin
            if (restart) begin
                state_reg   <= CS_LOAD;
                cls_cnt_reg <= CLS_FACE;
            end else begin
                unique case (state_reg)
                    CS_IDLE: begin
                    end
                    CS_LOAD: begin
                        div_q_reg   <= dividend;
                        div_r_reg   <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= CS_DIV;
                    end
                    CS_DIV: begin
                        div_q_reg <= {div_q_reg[BYTES_W-2:0], q_bit};
                        div_r_reg <= rem_new;
                        if (div_cnt_reg == DIVC_W'(BYTES_W - 1)) begin
                            state_reg <= CS_STORE;
                        end else begin
                            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
                        end
                    end
                    CS_STORE: begin
                        // zero flit size saturates
                        flits_reg[cls_cnt_reg] <= (flit_bytes_reg == '0) ? '1 : ceil_q;
                        if (cls_cnt_reg == CLS_CORNER) begin
                            state_reg <= CS_IDLE;
                        end else begin
                            cls_cnt_reg <= cls_cnt_reg + 2'd1;
                            state_reg   <= CS_LOAD;
                        end
                    end
                    default: state_reg <= CS_IDLE;
                endcase
            end

            if (wr) begin
                unique case (cfg_index)
                    REG_X_SIZE:       x_size_reg       <= cfg_data[SIZE_W-1:0];
                    REG_Y_SIZE:       y_size_reg       <= cfg_data[SIZE_W-1:0];
                    REG_Z_SIZE:       z_size_reg       <= cfg_data[SIZE_W-1:0];
                    REG_FACE_BYTES:   face_bytes_reg   <= cfg_data;
                    REG_EDGE_BYTES:   edge_bytes_reg   <= cfg_data;
                    REG_CORNER_BYTES: corner_bytes_reg <= cfg_data;
                    REG_FLIT_BYTES:   flit_bytes_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign cfg_o.xn    = clamp_dim(x_size_reg);
    assign cfg_o.yn    = clamp_dim(y_size_reg);
    assign cfg_o.zn    = clamp_dim(z_size_reg);
    assign cfg_o.flits = flits_reg;
    assign cfg_o.busy  = (state_reg != CS_IDLE);

    a_zero_flit_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_IDLE && flit_bytes_reg == '0) |-> (flits_reg == '1))
        else $error("flit counts not saturated for zero flit size");

    a_size_write_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (state_reg == CS_LOAD && cls_cnt_reg == CLS_FACE))
        else $error("byte size write did not restart the divider");

    a_store_after_full_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_STORE) |-> (div_cnt_reg == DIVC_W'(BYTES_W - 1)))
        else $error("flit count stored before division finished");

endmodule

[hdl/s27hne_front.sv]
// ---------------------------------------------------------------------------
// s27hne_front
// Accepts node coordinates, checks them against the grid and builds the
// mask of stencil neighbours that lie inside it.
// ---------------------------------------------------------------------------
module s27hne_front
    import s27hne_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  cfg_t                 cfg_i,
    input  logic                 q_ready,
    output logic                 q_push,
    output q_entry_t             q_entry
);

    logic [COORD_W-1:0]  x, y, z;
    logic                x_in, y_in, z_in;
    logic                x_neg, y_neg, z_neg;
    logic                x_pos, y_pos, z_pos;
    logic [NUM_DIRS-1:0] mask;

    function automatic logic axis_ok(logic neg_ok, logic pos_ok, ofs_t d);
        unique case (d)
            OFS_NEG: return neg_ok;
            OFS_POS: return pos_ok;
            default: return 1'b1;
        endcase
    endfunction

    assign x = s_tdata[COORD_W-1:0];
    assign y = s_tdata[2*COORD_W-1:COORD_W];
    assign z = s_tdata[3*COORD_W-1:2*COORD_W];

    always_comb begin
        x_in  = EXT_W'(x) < EXT_W'(cfg_i.xn);
        y_in  = EXT_W'(y) < EXT_W'(cfg_i.yn);
        z_in  = EXT_W'(z) < EXT_W'(cfg_i.zn);
        x_neg = (x != '0);
        y_neg = (y != '0);
        z_neg = (z != '0);
        x_pos = (EXT_W'(x) + EXT_W'(1)) < EXT_W'(cfg_i.xn);
        y_pos = (EXT_W'(y) + EXT_W'(1)) < EXT_W'(cfg_i.yn);
        z_pos = (EXT_W'(z) + EXT_W'(1)) < EXT_W'(cfg_i.zn);
        for (int i = 0; i < NUM_DIRS; i++) begin
            mask[i] = axis_ok(x_neg, x_pos, DIR_TAB[i].dx) &&
                      axis_ok(y_neg, y_pos, DIR_TAB[i].dy) &&
                      axis_ok(z_neg, z_pos, DIR_TAB[i].dz);
        end
    end

    always_comb begin
        q_entry.x = x;
        q_entry.y = y;
        q_entry.z = z;
        if (!(x_in && y_in && z_in)) begin
            q_entry.st   = ST_RANGE;
            q_entry.mask = '0;
        end else if (mask == '0) begin
            q_entry.st   = ST_LONE;
            q_entry.mask = '0;
        end else begin
            q_entry.st   = ST_NBR;
            q_entry.mask = mask;
        end
    end

    // hold off while flit counts are being recomputed
    assign s_tready = q_ready && !cfg_i.busy;
    assign q_push   = s_tvalid && s_tready;

endmodule

[hdl/s27hne_queue.sv]
// ---------------------------------------------------------------------------
// s27hne_queue
// Short queue of classified node jobs between the front and back parts.
// ---------------------------------------------------------------------------
module s27hne_queue
    import s27hne_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     push_ready,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     pop_valid
);

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

[hdl/s27hne_back.sv]
// ---------------------------------------------------------------------------
// s27hne_back
// Walks each job's neighbour mask, one neighbour a cycle unless the output
// stalls, and computes the linear index in a short multiply pipeline.
// ---------------------------------------------------------------------------
module s27hne_back
    import s27hne_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg_i,
    input  logic                 q_valid,
    input  q_entry_t             q_entry,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // neighbor_index, neighbor_class, flit_count
    output logic [1:0]           m_tuser,   // status
    output logic                 m_tlast    // last_result
);

    // job being walked
    logic                w_valid_reg;
    st_t                 w_st_reg;
    logic [COORD_W-1:0]  w_x_reg, w_y_reg, w_z_reg;
    logic [NUM_DIRS-1:0] w_mask_reg;

    // stage a: neighbour coordinates
    logic                a_valid_reg, a_last_reg;
    st_t                 a_st_reg;
    cls_t                a_cls_reg;
    logic [BYTES_W-1:0]  a_flit_reg;
    logic [NC_W-1:0]     a_nx_reg, a_ny_reg, a_nz_reg;

    // stage b: yn * nz
    logic                b_valid_reg, b_last_reg;
    st_t                 b_st_reg;
    cls_t                b_cls_reg;
    logic [BYTES_W-1:0]  b_flit_reg;
    logic [NC_W-1:0]     b_nx_reg, b_ny_reg;
    logic [T_W-1:0]      b_t_reg;

    // stage c: xn * (ny + yn * nz)
    logic                c_valid_reg, c_last_reg;
    st_t                 c_st_reg;
    cls_t                c_cls_reg;
    logic [BYTES_W-1:0]  c_flit_reg;
    logic [NC_W-1:0]     c_nx_reg;
    logic [P_W-1:0]      c_p_reg;

    // output beat
    logic                o_valid_reg, o_last_reg;
    st_t                 o_st_reg;
    cls_t                o_cls_reg;
    logic [BYTES_W-1:0]  o_flit_reg;
    logic [IDX_W-1:0]    o_idx_reg;

    logic                adv;
    logic                issue;
    logic                item_last;
    logic [DIR_W-1:0]    sel;
    logic [NUM_DIRS-1:0] mask_rest;
    dir_t                dir;
    logic [T_W:0]        u_sum;
    logic [P_W:0]        lin_sum;

    function automatic logic [NC_W-1:0] step(logic [COORD_W-1:0] c, ofs_t d);
        unique case (d)
            OFS_NEG: return NC_W'(c) - NC_W'(1);
            OFS_POS: return NC_W'(c) + NC_W'(1);
            default: return NC_W'(c);
        endcase
    endfunction

    assign adv = !o_valid_reg || m_tready;

    // lowest pending neighbour comes first
    always_comb begin
        sel = '0;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (w_mask_reg[i]) begin
                sel = DIR_W'(i);
            end
        end
        mask_rest      = w_mask_reg;
        mask_rest[sel] = 1'b0;
        dir            = DIR_TAB[sel];
        item_last      = (w_st_reg != ST_NBR) || (mask_rest == '0);
        issue          = w_valid_reg && adv;
        q_pop          = q_valid && (!w_valid_reg || (issue && item_last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                w_valid_reg <= 1'b1;
                w_st_reg    <= q_entry.st;
                w_x_reg     <= q_entry.x;
                w_y_reg     <= q_entry.y;
                w_z_reg     <= q_entry.z;
                w_mask_reg  <= q_entry.mask;
            end else if (issue && item_last) begin
                w_valid_reg <= 1'b0;
            end else if (issue) begin
                w_mask_reg <= mask_rest;
            end
        end
    end

    assign u_sum   = {1'b0, b_t_reg} + (T_W + 1)'(b_ny_reg);
    assign lin_sum = (P_W + 1)'(c_nx_reg) + (P_W + 1)'(c_p_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            o_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_st_reg   <= w_st_reg;
            a_last_reg <= item_last;
            a_cls_reg  <= (w_st_reg == ST_NBR) ? dir.cls : CLS_FACE;
            a_flit_reg <= (w_st_reg == ST_NBR) ? cfg_i.flits[dir.cls] : '0;
            a_nx_reg   <= step(w_x_reg, dir.dx);
            a_ny_reg   <= step(w_y_reg, dir.dy);
            a_nz_reg   <= step(w_z_reg, dir.dz);

            b_st_reg   <= a_st_reg;
            b_last_reg <= a_last_reg;
            b_cls_reg  <= a_cls_reg;
            b_flit_reg <= a_flit_reg;
            b_nx_reg   <= a_nx_reg;
            b_ny_reg   <= a_ny_reg;
            b_t_reg    <= T_W'(cfg_i.yn) * T_W'(a_nz_reg);

            c_st_reg   <= b_st_reg;
            c_last_reg <= b_last_reg;
            c_cls_reg  <= b_cls_reg;
            c_flit_reg <= b_flit_reg;
            c_nx_reg   <= b_nx_reg;
            c_p_reg    <= P_W'(cfg_i.xn) * P_W'(u_sum);

            o_st_reg   <= c_st_reg;
            o_last_reg <= c_last_reg;
            o_cls_reg  <= c_cls_reg;
            o_flit_reg <= c_flit_reg;
            o_idx_reg  <= (c_st_reg == ST_NBR) ? IDX_W'(lin_sum) : '0;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_st_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = M_TDATA_W'({o_flit_reg, o_cls_reg, o_idx_reg});

    a_status_beat_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_NBR) |-> (m_tlast && m_tdata == '0))
        else $error("status beat not final or not cleared");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_nbr_job_has_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (w_valid_reg && w_st_reg == ST_NBR) |-> (w_mask_reg != '0))
        else $error("neighbour job with empty mask");

endmodule

[hdl/stencil27_halo_neighbor_enumerator.sv]
// ---------------------------------------------------------------------------
// stencil27_halo_neighbor_enumerator
// Lists the in-grid 27-point stencil neighbours of a node with linear index,
// class and flit count; front classifier, job queue and back sequencer.
// ---------------------------------------------------------------------------
// path: queue entry, walk register, stages a, b and c, output register
// throughput: one result beat a cycle while m_tready holds; a node gives one
//   beat per neighbour (26 inside the grid), a status result a single beat
// reset: grid 1x1x1, all byte sizes 1, flit counts 1; after a write to a byte
//   or flit size register s_tready stays low while the serial divider
//   recomputes the flit counts
module stencil27_halo_neighbor_enumerator
    import s27hne_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord, z_coord
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // neighbor_index, neighbor_class, flit_count
    output logic [1:0]           m_tuser,   // status
    output logic                 m_tlast,   // last_result
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTES_W-1:0]   cfg_data
);

    cfg_t     cfg;
    logic     q_ready;
    logic     q_push;
    q_entry_t q_in;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_out;

    s27hne_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    s27hne_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_i    (cfg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    s27hne_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .pop_valid  (q_valid)
    );

    s27hne_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_i    (cfg),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the 27-point halo neighbour enumerator: drives
// node coordinates and register writes, predicts every neighbour beat and
// status beat in a scoreboard, and compares the result stream field by field.
// ---------------------------------------------------------------------------
module testbench;
    import s27hne_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        st_t               st;
        logic [IDX_W-1:0]  idx;
        cls_t              cls;
        logic [31:0]       flits;
        logic              last;
    } halo_beat_t;

    class halo_board;
        logic [SIZE_W-1:0]  ext [3];
        logic [BYTES_W-1:0] cls_bytes [3];
        logic [BYTES_W-1:0] flit_sz;
        halo_beat_t         due [$];
        int                 errors;
        int                 beats;

        function new();
            for (int a = 0; a < 3; a++) begin
                ext[a]       = 1;
                cls_bytes[a] = 1;
            end
            flit_sz = 1;
            errors  = 0;
            beats   = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string msg);
            if (errors < 50) begin
                $display("mismatch at beat %0d: %s", beats, msg);
            end
            errors++;
        endtask

        function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
            case (idx)
                REG_X_SIZE:       ext[0] = data[SIZE_W-1:0];
                REG_Y_SIZE:       ext[1] = data[SIZE_W-1:0];
                REG_Z_SIZE:       ext[2] = data[SIZE_W-1:0];
                REG_FACE_BYTES:   cls_bytes[CLS_FACE] = data;
                REG_EDGE_BYTES:   cls_bytes[CLS_EDGE] = data;
                REG_CORNER_BYTES: cls_bytes[CLS_CORNER] = data;
                REG_FLIT_BYTES:   flit_sz = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] flits_needed(logic [31:0] bytes);
            logic [31:0] q;
            if (flit_sz == 0) begin
                return '1;
            end
            q = bytes / flit_sz;
            if (bytes % flit_sz != 0) begin
                q++;
            end
            return q;
        endfunction

        function void push_status(st_t s);
            halo_beat_t b;
            b = '{st: s, idx: '0, cls: CLS_FACE, flits: '0, last: 1'b1};
            due.push_back(b);
        endfunction

        function void note_coord(logic [7:0] x, logic [7:0] y, logic [7:0] z);
            int          n [3];
            int          c [3];
            int          p [3];
            ofs_t        o [3];
            logic [31:0] fl [3];
            longint      lin;
            halo_beat_t  b;
            bit          have;
            bit          ok;
            c = '{int'(x), int'(y), int'(z)};
            for (int a = 0; a < 3; a++) begin
                n[a] = (ext[a] > 9'd256) ? 256 : int'(ext[a]);
            end
            if (c[0] >= n[0] || c[1] >= n[1] || c[2] >= n[2]) begin
                push_status(ST_RANGE);
                return;
            end
            for (int k = 0; k < 3; k++) begin
                fl[k] = flits_needed(cls_bytes[k]);
            end
            have = 0;
            for (int i = 0; i < NUM_DIRS; i++) begin
                o  = '{DIR_TAB[i].dx, DIR_TAB[i].dy, DIR_TAB[i].dz};
                ok = 1;
                for (int a = 0; a < 3; a++) begin
                    case (o[a])
                        OFS_NEG: begin
                            ok   = ok && (c[a] > 0);
                            p[a] = c[a] - 1;
                        end
                        OFS_POS: begin
                            ok   = ok && (c[a] + 1 < n[a]);
                            p[a] = c[a] + 1;
                        end
                        default: p[a] = c[a];
                    endcase
                end
                if (ok) begin
                    // hold one beat back so the final one can carry last
                    if (have) begin
                        due.push_back(b);
                    end
                    lin  = longint'(p[0]) + longint'(n[0]) *
                           (longint'(p[1]) + longint'(n[1]) * longint'(p[2]));
                    b    = '{st: ST_NBR, idx: lin[IDX_W-1:0], cls: DIR_TAB[i].cls,
                             flits: fl[DIR_TAB[i].cls], last: 1'b0};
                    have = 1;
                end
            end
            if (!have) begin
                push_status(ST_LONE);
            end else begin
                b.last = 1'b1;
                due.push_back(b);
            end
        endfunction

        task field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        task check_beat(logic [M_TDATA_W-1:0] data, logic [1:0] user, logic last);
            halo_beat_t w;
            beats++;
            if (due.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                w = due.pop_front();
                field("status", 32'(user), 32'(w.st));
                field("neighbor_index", 32'(data[23:0]), 32'(w.idx));
                field("neighbor_class", 32'(data[25:24]), 32'(w.cls));
                field("flit_count", data[57:26], w.flits);
                field("last_result", 32'(last), 32'(w.last));
                field("tdata padding", 32'(data[63:58]), 32'd0);
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTES_W-1:0]   cfg_data = '0;

    bit        no_idle = 0;
    halo_board board = new();

    stencil27_halo_neighbor_enumerator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // receiver back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= no_idle || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    // entered at a falling edge; leaves s_tvalid high for a following beat
    task automatic send_coord(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_coord(x, y, z);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.note_cfg(idx, data);
        @(negedge aclk);
    endtask

    // size writes carry random upper bits, which the block must drop
    task automatic configure(input int xs, input int ys, input int zs, input logic [31:0] fb,
                             input logic [31:0] eb, input logic [31:0] cb,
                             input logic [31:0] fl);
        write_reg(REG_X_SIZE, {23'($urandom_range(0, 8388607)), 9'(xs)});
        write_reg(REG_Y_SIZE, {23'($urandom_range(0, 8388607)), 9'(ys)});
        write_reg(REG_Z_SIZE, {23'($urandom_range(0, 8388607)), 9'(zs)});
        write_reg(REG_FACE_BYTES, fb);
        write_reg(REG_EDGE_BYTES, eb);
        write_reg(REG_CORNER_BYTES, cb);
        write_reg(REG_FLIT_BYTES, fl);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
    endtask

    function automatic int rand_ext();
        int r;
        r = $urandom_range(0, 39);
        if (r < 26) return $urandom_range(1, 6);
        if (r < 30) return $urandom_range(7, 255);
        if (r < 33) return 256;
        if (r < 37) return $urandom_range(257, 511);
        return 0;
    endfunction

    function automatic logic [31:0] rand_bytes();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return '1;
        if (r < 6) return $urandom_range(1, 64);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_flit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'd1;
        if (r == 2) return '1;
        if (r < 7) return $urandom_range(1, 16);
        return $urandom;
    endfunction

    function automatic logic [7:0] rand_coord(int ext);
        int n;
        n = (ext > 256) ? 256 : ext;
        if (n > 0 && $urandom_range(0, 99) < 85) begin
            return 8'($urandom_range(0, n - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int xs, ys, zs;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset grid is a single node; the spare index must change nothing
        write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        send_coord(8'd0, 8'd0, 8'd0);
        send_coord(8'd1, 8'd0, 8'd0);
        send_coord(8'd0, 8'd0, 8'd255);
        drain();

        // small cube, zero edge bytes, largest corner message
        configure(3, 3, 3, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'd7);
        send_coord(8'd1, 8'd1, 8'd1);
        send_coord(8'd0, 8'd0, 8'd0);
        send_coord(8'd2, 8'd2, 8'd2);
        send_coord(8'd1, 8'd0, 8'd2);
        send_coord(8'd3, 8'd1, 8'd1);
        send_coord(8'd1, 8'd3, 8'd1);
        send_coord(8'd1, 8'd1, 8'd3);
        drain();

        // largest grid, zero flit size
        configure(256, 256, 256, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd0);
        send_coord(8'd255, 8'd255, 8'd255);
        send_coord(8'd0, 8'd0, 8'd0);
        send_coord(8'd128, 8'd255, 8'd1);
        send_coord(8'd170, 8'd85, 8'd0);
        drain();

        // extents above the maximum saturate
        configure(511, 300, 257, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_coord(8'd255, 8'd255, 8'd255);
        send_coord(8'd0, 8'd255, 8'd7);
        send_coord(8'd85, 8'd170, 8'd255);
        drain();

        // zero extent: everything out of range
        configure(0, 2, 1, 32'd3, 32'd3, 32'd3, 32'd2);
        send_coord(8'd0, 8'd0, 8'd0);
        drain();

        // one-dimensional grids, faces only
        configure(1, 1, 2, 32'd9, 32'd1, 32'd1, 32'd4);
        send_coord(8'd0, 8'd0, 8'd0);
        send_coord(8'd0, 8'd0, 8'd1);
        drain();
        configure(2, 1, 1, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        send_coord(8'd0, 8'd0, 8'd0);
        send_coord(8'd1, 8'd0, 8'd0);
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            xs = rand_ext();
            ys = rand_ext();
            zs = rand_ext();
            if (ph == 2) begin
                xs = 256;
                ys = 256;
                zs = 256;
            end
            configure(xs, ys, zs, rand_bytes(), rand_bytes(), rand_bytes(), rand_flit());
            no_idle = (ph == 4);
            for (int i = 0; i < 34; i++) begin
                if (ph == 7 && i == 17) begin
                    drain();
                end
                send_coord(rand_coord(xs), rand_coord(ys), rand_coord(zs));
            end
            drain();
            no_idle = 0;
        end

        repeat (20) @(negedge aclk);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[stencil27_halo_neighbor_enumerator.f]
hdl/s27hne_pkg.sv
hdl/s27hne_cfg.sv
hdl/s27hne_front.sv
hdl/s27hne_queue.sv
hdl/s27hne_back.sv
hdl/stencil27_halo_neighbor_enumerator.sv
dv/testbench.sv
